@@ rtl/lr_pkg.sv @@
// Shared codes, register map and types for the line rasteriser.
package lr_pkg;

   // item kinds carried on req_tuser
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // decision rule codes held in the algorithm register
   localparam logic ALGO_MIDPOINT  = 1'b0;
   localparam logic ALGO_BRESENHAM = 1'b1;

   // register port geometry: one 32-bit register at byte address 0
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_INDEX_BITS = CSR_ADDR_BITS - 2;

   // register indexes (word address)
   localparam logic [CSR_INDEX_BITS-1:0] REG_ALGORITHM = 1'b0;

   // per-line control flags handed from setup to the stepper
   typedef struct packed {
      logic minor_down;   // minor axis counts down
      logic axis_is_y;    // y is the major axis
      logic algo;         // decision rule latched at line start
   } line_flags_type;

endpackage

@@ rtl/lr_csr.sv @@
// Configuration register block: holds the decision rule select.
module lr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [lr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [lr_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                             csr_pready,
   output logic                             algorithm
);
   import lr_pkg::*;

   logic                      algorithm_ff;
   logic                      algorithm_in;
   logic [CSR_INDEX_BITS-1:0] reg_index;
   logic                      wr_en;

   // word index from the byte address
   assign reg_index = csr_paddr[CSR_ADDR_BITS-1:2];
   assign wr_en     = csr_psel && csr_penable && csr_pwrite;

   // write decode: only bit 0 of the data is kept
   always_comb begin
      algorithm_in = algorithm_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_ALGORITHM: algorithm_in = csr_pwdata[0];
            default:       algorithm_in = algorithm_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         algorithm_ff <= ALGO_MIDPOINT;
      end else begin
         algorithm_ff <= algorithm_in;
      end
   end

   // read decode
   always_comb begin
      unique case (reg_index)
         REG_ALGORITHM: csr_prdata = CSR_DATA_BITS'(algorithm_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign algorithm  = algorithm_ff;

endmodule

@@ rtl/lr_setup.sv @@
// Line setup: orders the endpoints, picks the octant family and seeds the decision term.
module lr_setup #(
   parameter int COORD_BITS = 16
) (
   input  logic signed [COORD_BITS-1:0] x_start,
   input  logic signed [COORD_BITS-1:0] y_start,
   input  logic signed [COORD_BITS-1:0] x_end,
   input  logic signed [COORD_BITS-1:0] y_end,
   input  logic                         algorithm,
   output logic                         degenerate,
   output logic signed [COORD_BITS-1:0] first_x,
   output logic signed [COORD_BITS-1:0] first_y,
   output logic signed [COORD_BITS-1:0] major_end,
   output logic signed [COORD_BITS+3:0] decision,
   output logic signed [COORD_BITS+3:0] inc_straight,
   output logic signed [COORD_BITS+3:0] inc_diagonal,
   output lr_pkg::line_flags_type       flags
);
   import lr_pkg::*;

   localparam int DW = COORD_BITS + 4;

   logic signed [DW-1:0] x1, y1, x2, y2;
   logic signed [DW-1:0] dx, dy, adx, ady;
   logic signed [DW-1:0] big, minor_raw, m, two_m, two_big;
   logic                 axis_y;
   logic                 swap;
   logic                 md;

   // deltas and their magnitudes, at decision width
   assign x1  = DW'(x_start);
   assign y1  = DW'(y_start);
   assign x2  = DW'(x_end);
   assign y2  = DW'(y_end);
   assign dx  = x2 - x1;
   assign dy  = y2 - y1;
   assign adx = (dx < 0) ? -dx : dx;
   assign ady = (dy < 0) ? -dy : dy;

   // equal lengths stay x-major; swap so the major axis runs upward
   assign axis_y    = adx < ady;
   assign swap      = axis_y ? (y_start > y_end) : (x_start > x_end);
   assign big       = axis_y ? ady : adx;
   assign minor_raw = axis_y ? dx : dy;
   assign m         = swap ? -minor_raw : minor_raw;
   assign md        = m < 0;
   assign two_m     = m + m;
   assign two_big   = big + big;

   assign degenerate = (x_start == x_end) && (y_start == y_end);
   assign first_x    = swap ? x_end : x_start;
   assign first_y    = swap ? y_end : y_start;
   assign major_end  = axis_y ? (swap ? y_start : y_end) : (swap ? x_start : x_end);

   // decision term and increments for the chosen rule
   always_comb begin
      case (algorithm)
         ALGO_MIDPOINT: begin
            inc_straight = -two_m;
            if (!md) begin
               decision     = big - two_m;
               inc_diagonal = two_big - two_m;
            end else begin
               decision     = -two_m - big;
               inc_diagonal = -two_m - two_big;
            end
         end
         default: begin
            inc_straight = two_m;
            if (!md) begin
               decision     = -big;
               inc_diagonal = -two_big;
            end else begin
               decision     = big;
               inc_diagonal = two_big;
            end
         end
      endcase
   end

   assign flags.minor_down = md;
   assign flags.axis_is_y  = axis_y;
   assign flags.algo       = algorithm;

endmodule

@@ rtl/lr_step.sv @@
// Line stepper: advances one pixel along the major axis and updates the decision term.
module lr_step #(
   parameter int COORD_BITS = 16
) (
   input  logic signed [COORD_BITS-1:0] cur_x,
   input  logic signed [COORD_BITS-1:0] cur_y,
   input  logic signed [COORD_BITS-1:0] major_end,
   input  logic signed [COORD_BITS+3:0] decision,
   input  logic signed [COORD_BITS+3:0] inc_straight,
   input  logic signed [COORD_BITS+3:0] inc_diagonal,
   input  lr_pkg::line_flags_type       flags,
   output logic signed [COORD_BITS-1:0] next_x,
   output logic signed [COORD_BITS-1:0] next_y,
   output logic signed [COORD_BITS+3:0] next_decision,
   output logic                         last
);
   import lr_pkg::*;

   localparam int DW = COORD_BITS + 4;
   localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1);

   logic signed [DW-1:0]         straight_sum;
   logic signed [DW-1:0]         mid_sum;
   logic                         diag;
   logic signed [COORD_BITS-1:0] major, minor, major_n, minor_n;

   // Bresenham rule adds the straight term before testing
   assign straight_sum = decision + inc_straight;

   // decision test and update
   always_comb begin
      case (flags.algo)
         ALGO_MIDPOINT: begin
            diag          = flags.minor_down ? (decision > 0) : (decision < 0);
            mid_sum       = diag ? inc_diagonal : inc_straight;
            next_decision = decision + mid_sum;
         end
         default: begin
            diag          = flags.minor_down ? (straight_sum <= 0) : (straight_sum >= 0);
            mid_sum       = straight_sum + inc_diagonal;
            next_decision = diag ? mid_sum : straight_sum;
         end
      endcase
   end

   // move along major axis, minor axis on a diagonal step
   assign major   = flags.axis_is_y ? cur_y : cur_x;
   assign minor   = flags.axis_is_y ? cur_x : cur_y;
   assign major_n = major + ONE;
   assign minor_n = !diag ? minor : (flags.minor_down ? (minor - ONE) : (minor + ONE));

   assign next_x = flags.axis_is_y ? minor_n : major_n;
   assign next_y = flags.axis_is_y ? major_n : minor_n;
   assign last   = major_n >= major_end;

endmodule

@@ rtl/line_rasterizer.sv @@
// Top level of the integer line rasteriser: item registers, line state and result register.
//
// Each accepted item takes one pass through the design: it is held in an input
// register, worked on by the setup or stepping logic against the line state, and
// its pixel is written into the result register. One item is accepted per clock
// while the result side keeps up, so a start item followed by step items yields
// one pixel per cycle. A start item always gives its first pixel (or the single
// pixel of a point); a step item gives the next pixel, with tlast on the far
// endpoint, and gives nothing when no line is in progress. The rule selected in
// the algorithm register is taken when a line starts.
module line_rasterizer #(
   parameter  int COORD_BITS = 16,
   localparam int REQ_BITS   = ((4 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [REQ_BITS-1:0]              req_tdata,  // x_start, y_start, x_end, y_end
   input  logic                             req_tuser,  // opcode
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_BITS-1:0]              rsp_tdata,  // pixel_x, pixel_y
   output logic                             rsp_tuser,  // y_major
   output logic                             rsp_tlast,  // last_pixel
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [lr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [lr_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                             csr_pready
);
   import lr_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int DW = COORD_BITS + 4;

   // configuration
   logic algorithm;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic                 in_op_ff;
   logic signed [CB-1:0] in_xs_ff, in_ys_ff, in_xe_ff, in_ye_ff;

   // line state
   logic                 busy_ff, busy_in;
   logic signed [CB-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [CB-1:0] major_end_ff, major_end_in;
   logic signed [DW-1:0] dec_ff, dec_in, incs_ff, incs_in, incd_ff, incd_in;
   line_flags_type       flags_ff, flags_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic signed [CB-1:0] pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic                 ymaj_ff, ymaj_in, last_ff, last_in;

   // setup and stepper outputs
   logic                 su_degenerate;
   logic signed [CB-1:0] su_x, su_y, su_major_end;
   logic signed [DW-1:0] su_dec, su_incs, su_incd;
   line_flags_type       su_flags;
   logic signed [CB-1:0] st_x, st_y;
   logic signed [DW-1:0] st_dec;
   logic                 st_last;

   logic fire;
   logic load;

   lr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .algorithm   (algorithm)
   );

   lr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
      .x_start      (in_xs_ff),
      .y_start      (in_ys_ff),
      .x_end        (in_xe_ff),
      .y_end        (in_ye_ff),
      .algorithm    (algorithm),
      .degenerate   (su_degenerate),
      .first_x      (su_x),
      .first_y      (su_y),
      .major_end    (su_major_end),
      .decision     (su_dec),
      .inc_straight (su_incs),
      .inc_diagonal (su_incd),
      .flags        (su_flags)
   );

   lr_step #(.COORD_BITS(COORD_BITS)) u_step (
      .cur_x         (cur_x_ff),
      .cur_y         (cur_y_ff),
      .major_end     (major_end_ff),
      .decision      (dec_ff),
      .inc_straight  (incs_ff),
      .inc_diagonal  (incd_ff),
      .flags         (flags_ff),
      .next_x        (st_x),
      .next_y        (st_y),
      .next_decision (st_dec),
      .last          (st_last)
   );

   // handshakes: the held item moves on once the result slot is free or draining
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign load       = req_tvalid && req_tready;

   assign in_valid_in = load ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   // per-item work against the line state
   always_comb begin
      busy_in      = busy_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      major_end_in = major_end_ff;
      dec_in       = dec_ff;
      incs_in      = incs_ff;
      incd_in      = incd_ff;
      flags_in     = flags_ff;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      ymaj_in      = ymaj_ff;
      last_in      = last_ff;
      out_valid_in = rsp_tready ? 1'b0 : out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b0;
         if (in_op_ff == OP_START) begin
            out_valid_in = 1'b1;
            if (su_degenerate) begin
               // a point: one pixel, no line in progress
               busy_in  = 1'b0;
               pix_x_in = in_xs_ff;
               pix_y_in = in_ys_ff;
               ymaj_in  = 1'b0;
               last_in  = 1'b1;
            end else begin
               busy_in      = 1'b1;
               cur_x_in     = su_x;
               cur_y_in     = su_y;
               major_end_in = su_major_end;
               dec_in       = su_dec;
               incs_in      = su_incs;
               incd_in      = su_incd;
               flags_in     = su_flags;
               pix_x_in     = su_x;
               pix_y_in     = su_y;
               ymaj_in      = su_flags.axis_is_y;
               last_in      = 1'b0;
            end
         end else if (busy_ff) begin
            out_valid_in = 1'b1;
            busy_in      = !st_last;
            cur_x_in     = st_x;
            cur_y_in     = st_y;
            dec_in       = st_dec;
            pix_x_in     = st_x;
            pix_y_in     = st_y;
            ymaj_in      = flags_ff.axis_is_y;
            last_in      = st_last;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload and line registers
   always_ff @(posedge clock) begin
      if (load) begin
         in_op_ff <= req_tuser;
         in_xs_ff <= req_tdata[CB-1:0];
         in_ys_ff <= req_tdata[2*CB-1:CB];
         in_xe_ff <= req_tdata[3*CB-1:2*CB];
         in_ye_ff <= req_tdata[4*CB-1:3*CB];
      end
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      major_end_ff <= major_end_in;
      dec_ff       <= dec_in;
      incs_ff      <= incs_in;
      incd_ff      <= incd_in;
      flags_ff     <= flags_in;
      pix_x_ff     <= pix_x_in;
      pix_y_ff     <= pix_y_in;
      ymaj_ff      <= ymaj_in;
      last_ff      <= last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_BITS'({pix_y_ff, pix_x_ff});
   assign rsp_tuser  = ymaj_ff;
   assign rsp_tlast  = last_ff;

`ifndef NO_ASSERTIONS
   // a step with no line in progress leaves the result slot empty
   a_idle_step_silent: assert property (@(posedge clock) disable iff (reset)
      fire && (in_op_ff == OP_STEP) && !busy_ff |=> !rsp_tvalid)
      else $error("step while idle produced a pixel");

   // a proper line start leaves a line in progress
   a_start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      fire && (in_op_ff == OP_START) && !su_degenerate |=> busy_ff)
      else $error("line start did not set busy");

   // the pixel flagged last always ends the line
   a_last_clears_busy: assert property (@(posedge clock) disable iff (reset)
      fire && out_valid_in && last_in |=> !busy_ff && rsp_tlast)
      else $error("last pixel left the line in progress");

   // a held item stays until it is worked on
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff)
      else $error("held item was dropped");
`endif

endmodule
